[rtl/core/ocu_pkg.sv]
// Shared types and constants of the one-bit control unit.
`default_nettype none
package ocu_pkg;

	localparam int BIT_MEM_BITS = 256;
	localparam int MEM_AW       = $clog2(BIT_MEM_BITS);
	localparam int CFG_IDX_W    = 8;

	localparam logic [MEM_AW-1:0] ADDR_RESULT = MEM_AW'(BIT_MEM_BITS - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FIRST  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LAST   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FIRST = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LAST  = CFG_IDX_W'(3);

	typedef enum logic [3:0] {
		OP_NOP0 = 4'd0,
		OP_LD   = 4'd1,
		OP_LDC  = 4'd2,
		OP_AND  = 4'd3,
		OP_ANDC = 4'd4,
		OP_OR   = 4'd5,
		OP_ORC  = 4'd6,
		OP_XNOR = 4'd7,
		OP_STO  = 4'd8,
		OP_STOC = 4'd9,
		OP_IEN  = 4'd10,
		OP_OEN  = 4'd11,
		OP_JMP  = 4'd12,
		OP_RTN  = 4'd13,
		OP_SKZ  = 4'd14,
		OP_NOPF = 4'd15
	} opcode_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_NOP0 = 2'd1,
		EV_RTN  = 2'd2,
		EV_NOPF = 2'd3
	} event_t;

	typedef struct packed {
		logic [3:0]        instr_code;
		logic [MEM_AW-1:0] instr_arg;
		logic              pin_level;
	} ocu_item_t;

	typedef struct packed {
		logic [MEM_AW-1:0] next_pc;
		logic              result_bit;
		logic              input_enabled;
		logic              output_enabled;
		logic              pin_sampled;
		logic              pin_drive;
		logic [MEM_AW-1:0] pin_address;
		logic              drive_level;
		logic [1:0]        event_code;
	} ocu_result_t;

	typedef struct packed {
		logic [MEM_AW-1:0] pc;
		logic              rbit;
		logic              ien;
		logic              oen;
	} ocu_state_t;

	typedef struct packed {
		logic [MEM_AW-1:0] input_first;
		logic [MEM_AW-1:0] input_last;
		logic [MEM_AW-1:0] output_first;
		logic [MEM_AW-1:0] output_last;
	} ocu_cfg_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic              data;
	} ocu_mem_wr_t;

endpackage
`default_nettype wire

[rtl/core/ocu_item_if.sv]
// Instruction item channel with valid/ready handshake.
`default_nettype none
interface ocu_item_if;
	logic              valid;
	logic              ready;
	ocu_pkg::ocu_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/ocu_result_if.sv]
// Result item channel with valid/ready handshake.
`default_nettype none
interface ocu_result_if;
	logic                 valid;
	logic                 ready;
	ocu_pkg::ocu_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/ocu_cfg_if.sv]
// Configuration write channel with valid/ready handshake.
`default_nettype none
interface ocu_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ocu_pkg::CFG_IDX_W-1:0]     reg_index;
	logic [ocu_pkg::MEM_AW-1:0]        wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

[rtl/core/ocu_cfg_regs.sv]
// Configuration registers holding the input and output pin address ranges.
`default_nettype none
module ocu_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	ocu_cfg_if.sink           cfg,
	output ocu_pkg::ocu_cfg_t ranges
);

	ocu_pkg::ocu_cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign ranges    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_first  <= ocu_pkg::MEM_AW'(1);
			cfg_q.input_last   <= '0;
			cfg_q.output_first <= ocu_pkg::MEM_AW'(1);
			cfg_q.output_last  <= '0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				ocu_pkg::CFG_INPUT_FIRST:  cfg_q.input_first  <= cfg.wr_data;
				ocu_pkg::CFG_INPUT_LAST:   cfg_q.input_last   <= cfg.wr_data;
				ocu_pkg::CFG_OUTPUT_FIRST: cfg_q.output_first <= cfg.wr_data;
				ocu_pkg::CFG_OUTPUT_LAST:  cfg_q.output_last  <= cfg.wr_data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/ocu_bitmem.sv]
// Bit memory with per-entry valid bits, registered read and write bypass.
`default_nettype none
module ocu_bitmem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [ocu_pkg::MEM_AW-1:0] rd_addr,
	input  ocu_pkg::ocu_mem_wr_t       wr,
	output logic                       rd_bit
);

	logic                               mem_q [ocu_pkg::BIT_MEM_BITS];
	logic [ocu_pkg::BIT_MEM_BITS-1:0]   vld_q;
	logic                               rd_raw_q;
	logic                               rd_vld_q;
	logic                               byp_q;
	logic                               byp_dat_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_raw_q  <= mem_q[rd_addr];
			byp_q     <= wr.en && (wr.addr == rd_addr);
			byp_dat_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// A write in the same cycle as the read wins over the stored entry.
	assign rd_bit = byp_q ? byp_dat_q : (rd_vld_q & rd_raw_q);

endmodule
`default_nettype wire

[rtl/core/ocu_exec.sv]
// Instruction execute logic: operand selection, result update, stores and next pc.
`default_nettype none
module ocu_exec (
	input  ocu_pkg::ocu_item_t   item,
	input  ocu_pkg::ocu_state_t  st,
	input  ocu_pkg::ocu_cfg_t    ranges,
	input  logic                 mem_bit,
	input  logic                 fire,
	output ocu_pkg::ocu_state_t  st_nxt,
	output ocu_pkg::ocu_mem_wr_t mem_wr,
	output ocu_pkg::ocu_result_t res
);

	ocu_pkg::opcode_t           code;
	ocu_pkg::event_t            ev;
	logic [ocu_pkg::MEM_AW-1:0] arg;
	logic                       in_rng;
	logic                       out_rng;
	logic                       src_bit;
	logic                       op_bit;
	logic                       sto_bit;
	logic                       sampled;
	logic                       drive;
	logic                       dlevel;

	assign code = ocu_pkg::opcode_t'(item.instr_code);
	assign arg  = item.instr_arg;

	always_comb begin
		in_rng  = (arg >= ranges.input_first) && (arg <= ranges.input_last);
		out_rng = (arg >= ranges.output_first) && (arg <= ranges.output_last);
		src_bit = in_rng ? item.pin_level
			: ((arg == ocu_pkg::ADDR_RESULT) ? st.rbit : mem_bit);

		st_nxt      = st;
		st_nxt.pc   = st.pc + ocu_pkg::MEM_AW'(1);
		mem_wr      = '0;
		mem_wr.addr = arg;
		sampled     = 1'b0;
		drive       = 1'b0;
		dlevel      = 1'b0;
		op_bit      = 1'b0;
		sto_bit     = 1'b0;
		ev          = ocu_pkg::EV_NONE;

		if (code inside {[ocu_pkg::OP_LD:ocu_pkg::OP_XNOR]}) begin
			if (st.ien) begin
				op_bit      = src_bit;
				sampled     = in_rng;
				mem_wr.en   = in_rng;
				mem_wr.data = item.pin_level;
			end
			case (code)
				ocu_pkg::OP_LD:   st_nxt.rbit = op_bit;
				ocu_pkg::OP_LDC:  st_nxt.rbit = ~op_bit;
				ocu_pkg::OP_AND:  st_nxt.rbit = st.rbit & op_bit;
				ocu_pkg::OP_ANDC: st_nxt.rbit = st.rbit & ~op_bit;
				ocu_pkg::OP_OR:   st_nxt.rbit = st.rbit | op_bit;
				ocu_pkg::OP_ORC:  st_nxt.rbit = st.rbit | ~op_bit;
				default:          st_nxt.rbit = ~(st.rbit ^ op_bit);
			endcase
		end else begin
			case (code)
				ocu_pkg::OP_NOP0: ev = ocu_pkg::EV_NOP0;
				ocu_pkg::OP_STO, ocu_pkg::OP_STOC: begin
					if (st.oen) begin
						sto_bit     = (code == ocu_pkg::OP_STO) ? st.rbit : ~st.rbit;
						mem_wr.en   = 1'b1;
						mem_wr.data = sto_bit;
						drive       = out_rng;
						dlevel      = out_rng & sto_bit;
					end
				end
				ocu_pkg::OP_IEN: begin
					st_nxt.ien  = src_bit;
					sampled     = in_rng;
					mem_wr.en   = in_rng;
					mem_wr.data = item.pin_level;
				end
				ocu_pkg::OP_OEN: begin
					st_nxt.oen  = src_bit;
					sampled     = in_rng;
					mem_wr.en   = in_rng;
					mem_wr.data = item.pin_level;
				end
				ocu_pkg::OP_JMP: st_nxt.pc = arg;
				ocu_pkg::OP_RTN: ev = ocu_pkg::EV_RTN;
				ocu_pkg::OP_SKZ: begin
					if (!st.rbit) begin
						st_nxt.pc = st.pc + arg;
					end
				end
				default: ev = ocu_pkg::EV_NOPF;
			endcase
		end

		mem_wr.en = mem_wr.en & fire;

		res.next_pc        = st_nxt.pc;
		res.result_bit     = st_nxt.rbit;
		res.input_enabled  = st_nxt.ien;
		res.output_enabled = st_nxt.oen;
		res.pin_sampled    = sampled;
		res.pin_drive      = drive;
		res.pin_address    = arg;
		res.drive_level    = dlevel;
		res.event_code     = ev;
	end

endmodule
`default_nettype wire

[rtl/core/one_bit_control_unit_step.sv]
// Top level of the one-bit control unit instruction step block.
//
// The item channel brings one instruction (opcode, operand) together with the
// sampled level of the pin that the operand addresses. For every instruction
// the result channel returns one transaction with the program counter, the
// result and enable flags after the instruction and the pin activity it caused.
// The configuration channel sets the input and output pin address ranges; it
// is always ready and should only be written while no instruction is in flight.
// An accepted instruction is registered together with a registered read of the
// bit memory at its operand, then executed and placed in the result register,
// from which its result transaction is offered to the receiver.
// One instruction is accepted in every cycle while the receiver takes results;
// the state register loop through the execute logic sets this rate. When the
// receiver stalls, the result register holds, the instruction stage holds
// behind it, and the item channel drops ready once both are full. Reset clears
// the program counter, the flags and the valid bits of the bit memory and makes
// both pin ranges empty, so all memory bits read as zero right after reset.
`default_nettype none
module one_bit_control_unit_step (
	input  logic          clk,
	input  logic          arst_n,
	ocu_item_if.sink      item,
	ocu_result_if.source  result,
	ocu_cfg_if.sink       cfg
);

	ocu_pkg::ocu_cfg_t    ranges;
	ocu_pkg::ocu_item_t   item_s1;
	ocu_pkg::ocu_state_t  st_q;
	ocu_pkg::ocu_state_t  st_nxt;
	ocu_pkg::ocu_mem_wr_t mem_wr;
	ocu_pkg::ocu_result_t res_nxt;
	ocu_pkg::ocu_result_t res_q;
	logic                 s1_v_q;
	logic                 res_v_q;
	logic                 s1_fire;
	logic                 acc;
	logic                 mem_bit;

	assign s1_fire    = s1_v_q && (!res_v_q || result.ready);
	assign item.ready = !s1_v_q || s1_fire;
	assign acc        = item.valid && item.ready;

	ocu_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ranges (ranges)
	);

	ocu_bitmem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (item.data.instr_arg),
		.wr      (mem_wr),
		.rd_bit  (mem_bit)
	);

	ocu_exec u_exec (
		.item    (item_s1),
		.st      (st_q),
		.ranges  (ranges),
		.mem_bit (mem_bit),
		.fire    (s1_fire),
		.st_nxt  (st_nxt),
		.mem_wr  (mem_wr),
		.res     (res_nxt)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item.data;
		end
		if (s1_fire) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			res_v_q <= 1'b0;
			st_q    <= '0;
		end else begin
			if (acc) begin
				s1_v_q <= 1'b1;
			end else if (s1_fire) begin
				s1_v_q <= 1'b0;
			end
			if (s1_fire) begin
				res_v_q <= 1'b1;
				st_q    <= st_nxt;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign result.valid = res_v_q;
	assign result.data  = res_q;

endmodule
`default_nettype wire
